/* rtl/next_fit_page_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the next-fit page allocator
// property checks, all clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define NFPA_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("nfpa assertion failed");

// condition holds in the cycle after the trigger
`define NFPA_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("nfpa assertion failed");

`endif

/* rtl/nfpa_pkg.sv */
// ----------------------------------------------------------------------------
// nfpa_pkg
// shared constants, codes and types of the next-fit page allocator
// ----------------------------------------------------------------------------
package nfpa_pkg;

	localparam int HEAP_PAGES = 1024;
	localparam int PAGE_BYTES = 4096;   // power of two

	localparam int PAGE_W     = $clog2(HEAP_PAGES);
	localparam int CNT_W      = $clog2(HEAP_PAGES + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam int SIZE_W   = 23;
	localparam int IDX_W    = 10;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;
	localparam int NEED_W   = SIZE_W + 1 - PAGE_SHIFT;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FAIL    = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FLEN,
		S_FCLR
	} state_t;

	typedef struct packed {
		logic              we;
		logic [PAGE_W-1:0] addr;
		logic              wdata;
	} used_req_t;

	typedef struct packed {
		logic              we;
		logic [PAGE_W-1:0] addr;
		logic [CNT_W-1:0]  wdata;
	} len_req_t;

	typedef struct packed {
		logic               valid;
		status_t            status;
		logic [START_W-1:0] start_page;
	} result_t;

endpackage

/* rtl/nfpa_ram.sv */
// ----------------------------------------------------------------------------
// nfpa_ram
// generic single-port ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module nfpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/nfpa_ctrl.sv */
// ----------------------------------------------------------------------------
// nfpa_ctrl
// sequencer for clearing, next-fit scan, run marking and run release
// ----------------------------------------------------------------------------
`include "next_fit_page_allocator_top_assert.svh"

module nfpa_ctrl import nfpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  opcode_t           opcode,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [IDX_W-1:0]  page_index,
	input  logic              used_rdata,
	input  logic [CNT_W-1:0]  len_rdata,
	output logic              idle,
	output used_req_t         used_req,
	output len_req_t          len_req,
	output result_t           result
);

	state_t            state_q, state_d;
	logic [PAGE_W-1:0] ptr_q, ptr_d;
	logic [PAGE_W-1:0] step_q, step_d;
	logic [PAGE_W-1:0] begin_q, begin_d;
	logic [PAGE_W-1:0] nfp_q, nfp_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  need_q, need_d;
	logic [CNT_W-1:0]  rem_q, rem_d;

	// shared page pointer incrementer, wraps at the heap end
	logic [PAGE_W-1:0] ptr_inc;
	logic              ptr_last;

	logic [SIZE_W:0]   size_up;
	logic [NEED_W-1:0] need;
	logic              alloc_bad;
	logic              free_bad;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W-1:0]  cnt_new;
	logic [PAGE_W-1:0] begin_new;

	assign ptr_last = (32'(ptr_q) == HEAP_PAGES - 1);
	assign ptr_inc  = ptr_last ? '0 : ptr_q + PAGE_W'(1);

	assign size_up   = {1'b0, size_bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
	assign need      = size_up[SIZE_W:PAGE_SHIFT];
	assign alloc_bad = (size_bytes == '0) || (32'(need) > HEAP_PAGES);
	assign free_bad  = (32'(page_index) >= HEAP_PAGES);

	assign cnt_eff   = (ptr_q == '0) ? '0 : cnt_q;
	assign cnt_new   = cnt_eff + CNT_W'(1);
	assign begin_new = (cnt_eff == '0) ? ptr_q : begin_q;

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q   <= '0;
			step_q  <= '0;
			begin_q <= '0;
			nfp_q   <= '0;
			cnt_q   <= '0;
			need_q  <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			step_q  <= step_d;
			begin_q <= begin_d;
			nfp_q   <= nfp_d;
			cnt_q   <= cnt_d;
			need_q  <= need_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		step_d   = step_q;
		begin_d  = begin_q;
		nfp_d    = nfp_q;
		cnt_d    = cnt_q;
		need_d   = need_q;
		rem_d    = rem_q;
		used_req = '{we: 1'b0, addr: ptr_q, wdata: 1'b0};
		len_req  = '{we: 1'b0, addr: ptr_q, wdata: '0};
		result   = '{valid: 1'b0, status: ST_OK, start_page: '0};

		case (state_q)
			S_CLEAR: begin
				used_req.we = 1'b1;
				len_req.we  = 1'b1;
				ptr_d       = ptr_inc;
				if (ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_ALLOC) begin
						if (alloc_bad) begin
							result.valid  = 1'b1;
							result.status = ST_FAIL;
						end else begin
							used_req.addr = nfp_q;
							ptr_d         = nfp_q;
							step_d        = '0;
							cnt_d         = '0;
							need_d        = CNT_W'(need);
							state_d       = S_SCAN;
						end
					end else begin
						if (free_bad) begin
							result.valid  = 1'b1;
							result.status = ST_IGNORED;
						end else begin
							len_req.addr = PAGE_W'(page_index);
							ptr_d        = PAGE_W'(page_index);
							state_d      = S_FLEN;
						end
					end
				end
			end
			S_SCAN: begin
				// used_rdata belongs to ptr_q, fetch the following page meanwhile
				used_req.addr = ptr_inc;
				if (!used_rdata && cnt_new == need_q) begin
					begin_d = begin_new;
					ptr_d   = begin_new;
					rem_d   = need_q;
					state_d = S_MARK;
				end else begin
					if (!used_rdata) begin
						cnt_d   = cnt_new;
						begin_d = begin_new;
					end else begin
						cnt_d = '0;
					end
					if (32'(step_q) == HEAP_PAGES - 1) begin
						result.valid  = 1'b1;
						result.status = ST_FAIL;
						state_d       = S_IDLE;
					end else begin
						step_d = step_q + PAGE_W'(1);
						ptr_d  = ptr_inc;
					end
				end
			end
			S_MARK: begin
				used_req.we    = 1'b1;
				used_req.wdata = 1'b1;
				len_req.we     = (rem_q == need_q);
				len_req.addr   = begin_q;
				len_req.wdata  = need_q;
				rem_d          = rem_q - CNT_W'(1);
				ptr_d          = ptr_inc;
				if (rem_q == CNT_W'(1)) begin
					// page just past the run, already wrapped to zero at the heap end
					nfp_d             = ptr_inc;
					result.valid      = 1'b1;
					result.status     = ST_OK;
					result.start_page = START_W'(begin_q);
					state_d           = S_IDLE;
				end
			end
			S_FLEN: begin
				if (len_rdata == '0) begin
					result.valid  = 1'b1;
					result.status = ST_IGNORED;
					state_d       = S_IDLE;
				end else begin
					len_req.we = 1'b1;
					rem_d      = len_rdata;
					state_d    = S_FCLR;
				end
			end
			S_FCLR: begin
				used_req.we = 1'b1;
				rem_d       = rem_q - CNT_W'(1);
				ptr_d       = ptr_inc;
				if (rem_q == CNT_W'(1) || ptr_last) begin
					result.valid  = 1'b1;
					result.status = ST_OK;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`NFPA_ASSERT_SAME(a_scan_count, state_q == S_SCAN, cnt_q < need_q)
	`NFPA_ASSERT_SAME(a_rem_nonzero, state_q == S_MARK || state_q == S_FCLR, rem_q != '0)
	`NFPA_ASSERT_SAME(a_mark_in_heap, state_q == S_MARK,
		(CNT_W+1)'(ptr_q) + (CNT_W+1)'(rem_q) <= (CNT_W+1)'(HEAP_PAGES))
	`NFPA_ASSERT_NEXT(a_flen_exit, state_q == S_FLEN, state_q == S_IDLE || state_q == S_FCLR)

endmodule

/* rtl/next_fit_page_allocator_top.sv */
// ----------------------------------------------------------------------------
// next_fit_page_allocator_top
// page-granular next-fit allocator over a fixed heap of pages
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_axis    in   size_bytes[22:0] page_index[32:23]     opcode
//  m_axis    out  start_page[9:0]                        status[1:0]
//
//  allocate: a next-fit scan with one used-map read per cycle, then one page
//  marked per cycle
//  free: the run length is read, then one page released per cycle
//  zero, oversized or out-of-range requests answer in the accept cycle
//  after reset a clearing pass over all pages runs with s_axis_tready low
//  one request at a time; a waiting result holds in the output register
// ----------------------------------------------------------------------------
module next_fit_page_allocator_top import nfpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // size_bytes, page_index, zero fill
	input  logic        s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // start_page, zero fill
	output logic [1:0]  m_axis_tuser    // status
);

	logic               ctrl_idle;
	logic               accept;
	used_req_t          used_req;
	len_req_t           len_req;
	result_t            result;
	logic               used_rdata;
	logic [CNT_W-1:0]   len_rdata;
	logic               out_valid_q;
	status_t            status_q;
	logic [START_W-1:0] start_q;

	assign s_axis_tready = ctrl_idle && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	nfpa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode_t'(s_axis_tuser)),
		.size_bytes (s_axis_tdata[SIZE_W-1:0]),
		.page_index (s_axis_tdata[SIZE_W+IDX_W-1:SIZE_W]),
		.used_rdata (used_rdata),
		.len_rdata  (len_rdata),
		.idle       (ctrl_idle),
		.used_req   (used_req),
		.len_req    (len_req),
		.result     (result)
	);

	nfpa_ram #(
		.WIDTH (1),
		.DEPTH (HEAP_PAGES)
	) u_used_ram (
		.clk   (clk),
		.we    (used_req.we),
		.addr  (used_req.addr),
		.wdata (used_req.wdata),
		.rdata (used_rdata)
	);

	nfpa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (HEAP_PAGES)
	) u_len_ram (
		.clk   (clk),
		.we    (len_req.we),
		.addr  (len_req.addr),
		.wdata (len_req.wdata),
		.rdata (len_rdata)
	);

	// output register, a result only arrives while it is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			status_q <= result.status;
			start_q  <= result.start_page;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {(16 - START_W)'(0), start_q};

endmodule
